[design/fsubm_pkg.sv]
// Shared types and constants for the first-substring-match block.
package fsubm_pkg;

  localparam int IDX_W     = 5;
  localparam int BYTE_W    = 8;
  localparam int CFG_LEN_W = 6;
  localparam int FIELD_W   = 16;
  localparam int RESULT_W  = 1 + FIELD_W + FIELD_W + 1;

  typedef enum logic [1:0] {
    ACT_PAT_WR = 2'd0,
    ACT_TEXT   = 2'd1,
    ACT_END    = 2'd2,
    ACT_IDLE   = 2'd3
  } action_t;

  typedef struct packed {
    logic              text_en;
    logic              clear;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [BYTE_W-1:0] data;
  } cell_ctrl_t;

endpackage

[design/first_substring_match.sv]
// Top level: streamed first-occurrence substring search over a row of cells.
//
// Usage:
//   cfg channel: cfg_tdata[5:0] is the pattern length; always ready. Write only
//   while the block is idle. Lengths above MAX_PATTERN act as MAX_PATTERN.
//   in channel: in_tuser selects the request kind (pattern write, text byte,
//   end of text). Pattern writes load the cell at the given index; text bytes
//   are compared against every cell at once and the partial-match bits step
//   one cell along the row per byte.
//   out channel: one result per end-of-text request, on out_tvalid the cycle
//   after it is taken unless one is stalled; per-text state clears at once.
// Throughput: one request per cycle while in_tready is high, any mix of kinds.
//   Each text byte takes one compare per cell plus the partial-match shift.
// Stall: a result waits in the output register and a second one in a skid
//   stage; in_tready falls only while both are occupied and rises again the
//   cycle after out_tready takes a result.
// Reset (synchronous, rst_n low): pattern length, partial matches, position,
//   match flag and saturation flag clear; output is empty. The pattern bytes
//   are not cleared and must be written before use.
module first_substring_match #(
  parameter int MAX_PATTERN = 32,
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // config: [5:0] pattern_length, [7:6] zero
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata,
  // input: [4:0] pattern_index, [12:5] data_byte, [15:13] zero
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // input kind: [1:0] action
  input  logic [1:0]  in_tuser,
  // result: [0] found, [16:1] match_offset, [32:17] remaining,
  //         [33] length_overflow, [39:34] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int CMP_W = (LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W;
  localparam int EXT_W = (LENGTH_BITS > fsubm_pkg::FIELD_W) ? LENGTH_BITS
                                                            : fsubm_pkg::FIELD_W;
  localparam int PAD_W = 40 - fsubm_pkg::RESULT_W;

  logic [fsubm_pkg::CFG_LEN_W-1:0] len_r;
  logic [LEN_W-1:0]                act_len;
  logic [LENGTH_BITS-1:0]          pos_r;
  logic                            sat_r;
  logic                            seen_r;
  logic [LENGTH_BITS-1:0]          first_off_r;

  logic                            in_acc;
  fsubm_pkg::action_t              action;
  fsubm_pkg::cell_ctrl_t           ctrl;
  logic                            end_req;

  logic [MAX_PATTERN:0]            chain;
  logic [MAX_PATTERN-1:0]          hits;
  logic                            hit_any;

  logic [CMP_W-1:0]                pos_x;
  logic [CMP_W-1:0]                lm1;
  logic [LENGTH_BITS-1:0]          new_off;

  logic                            found_c;
  logic [LENGTH_BITS-1:0]          off_raw;
  logic [LENGTH_BITS-1:0]          off_c;
  logic [LENGTH_BITS-1:0]          rem_c;
  logic [EXT_W-1:0]                off_ext;
  logic [EXT_W-1:0]                rem_ext;
  logic [fsubm_pkg::RESULT_W-1:0]  result;
  logic                            push_ready;
  logic [fsubm_pkg::RESULT_W-1:0]  out_res;

  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_tvalid) begin
      len_r <= cfg_tdata[fsubm_pkg::CFG_LEN_W-1:0];
    end
  end

  // clamp the pattern length to the number of cells
  assign act_len = (32'(len_r) > MAX_PATTERN) ? LEN_W'(MAX_PATTERN) : LEN_W'(len_r);

  assign in_tready = push_ready;
  assign in_acc    = in_tvalid & in_tready;
  assign action    = fsubm_pkg::action_t'(in_tuser);

  always_comb begin
    ctrl.text_en = 1'b0;
    ctrl.clear   = 1'b0;
    ctrl.wr_en   = 1'b0;
    ctrl.wr_idx  = in_tdata[fsubm_pkg::IDX_W-1:0];
    ctrl.data    = in_tdata[fsubm_pkg::IDX_W +: fsubm_pkg::BYTE_W];
    unique case (action)
      fsubm_pkg::ACT_PAT_WR: ctrl.wr_en   = in_acc;
      fsubm_pkg::ACT_TEXT:   ctrl.text_en = in_acc;
      fsubm_pkg::ACT_END:    ctrl.clear   = in_acc;
      fsubm_pkg::ACT_IDLE:   ctrl.clear   = 1'b0;
      default:               ctrl.clear   = 1'b0;
    endcase
  end

  assign end_req = ctrl.clear;

  assign chain[0] = 1'b1;

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
    fsubm_cell #(
      .IDX   (g),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .act_len   (act_len),
      .carry_in  (chain[g]),
      .carry_out (chain[g+1]),
      .hit       (hits[g])
    );
  end

  assign hit_any = |hits;

  // start of the match ending at this byte
  assign pos_x   = CMP_W'(pos_r);
  assign lm1     = CMP_W'(act_len) - CMP_W'(1);
  assign new_off = (pos_x >= lm1) ? LENGTH_BITS'(pos_x - lm1) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      sat_r       <= 1'b0;
      seen_r      <= 1'b0;
      first_off_r <= '0;
    end else if (ctrl.clear) begin
      pos_r       <= '0;
      sat_r       <= 1'b0;
      seen_r      <= 1'b0;
      first_off_r <= '0;
    end else if (ctrl.text_en) begin
      if (hit_any && !seen_r) begin
        seen_r      <= 1'b1;
        first_off_r <= new_off;
      end
      if (&pos_r) begin
        sat_r <= 1'b1;
      end else begin
        pos_r <= pos_r + LENGTH_BITS'(1);
      end
    end
  end

  // an empty pattern always matches at the start
  assign found_c = (act_len == '0) | seen_r;
  assign off_raw = ((act_len != '0) && seen_r) ? first_off_r : '0;
  assign off_c   = (off_raw > pos_r) ? pos_r : off_raw;
  assign rem_c   = pos_r - off_c;
  assign off_ext = EXT_W'(off_c);
  assign rem_ext = EXT_W'(rem_c);

  assign result = {sat_r,
                   rem_ext[fsubm_pkg::FIELD_W-1:0],
                   off_ext[fsubm_pkg::FIELD_W-1:0],
                   found_c};

  fsubm_out_skid #(
    .W (fsubm_pkg::RESULT_W)
  ) u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (end_req),
    .push_data  (result),
    .push_ready (push_ready),
    .out_valid  (out_tvalid),
    .out_data   (out_res),
    .out_ready  (out_tready)
  );

  assign out_tdata = {{PAD_W{1'b0}}, out_res};

  a_seen_clears_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(seen_r) |-> $past(end_req))
    else $error("match flag cleared without an end-of-text request");

  a_sat_at_top: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (&pos_r))
    else $error("saturation flag set below the top count");

  a_offset_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (first_off_r <= pos_r))
    else $error("match offset beyond text position");

  a_cells_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    end_req |=> (chain[MAX_PATTERN:1] == '0))
    else $error("partial-match bits survive end of text");

endmodule

[design/fsubm_cell.sv]
// One pattern position: stored byte, partial-match bit and last-position hit.
module fsubm_cell #(
  parameter int IDX   = 0,
  parameter int LEN_W = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fsubm_pkg::cell_ctrl_t ctrl,
  input  logic [LEN_W-1:0]    act_len,
  input  logic                carry_in,
  output logic                carry_out,
  output logic                hit
);

  logic [fsubm_pkg::BYTE_W-1:0] pat_r;
  logic                         match_r;
  logic                         match_nxt;
  logic                         en;
  logic                         last;

  assign en        = (32'(act_len) > IDX);
  assign last      = (32'(act_len) == IDX + 1);
  assign match_nxt = en & carry_in & (ctrl.data == pat_r);
  assign carry_out = match_r;
  assign hit       = ctrl.text_en & last & match_nxt;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en && (32'(ctrl.wr_idx) == IDX)) begin
      pat_r <= ctrl.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.clear) begin
      match_r <= 1'b0;
    end else if (ctrl.text_en) begin
      match_r <= match_nxt;
    end
  end

endmodule

[design/fsubm_out_skid.sv]
// Output register with a skid stage for the result channel.
module fsubm_out_skid #(
  parameter int W = 34
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  input  logic [W-1:0] push_data,
  output logic         push_ready,
  output logic         out_valid,
  output logic [W-1:0] out_data,
  input  logic         out_ready
);

  logic         out_v_r;
  logic [W-1:0] out_d_r;
  logic         sk_v_r;
  logic [W-1:0] sk_d_r;
  logic         take;

  assign take       = out_v_r & out_ready;
  assign push_ready = ~sk_v_r;
  assign out_valid  = out_v_r;
  assign out_data   = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (sk_v_r) begin
      if (take) begin
        out_v_r <= 1'b1;
        sk_v_r  <= 1'b0;
      end
    end else if (!out_v_r || take) begin
      out_v_r <= push_valid;
    end else if (push_valid) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_v_r) begin
      if (take) begin
        out_d_r <= sk_d_r;
      end
    end else if (!out_v_r || take) begin
      out_d_r <= push_data;
    end else if (push_valid) begin
      sk_d_r <= push_data;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid stage holds a result while the output register is empty");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |=> out_v_r)
    else $error("stalled result dropped");

endmodule
